// ===== src/prm_pkg.sv =====
// Shared types and constants for the pulse rate meter.
package prm_pkg;

  localparam int TS_W      = 32;
  localparam int GAIN_W    = 24;
  localparam int TMO_W     = 12;
  localparam int RATE_W    = 44;
  localparam int CFG_IDX_W = 1;
  localparam int CNT_W     = 6;

  localparam logic [19:0] US_PER_S = 20'd1000000;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TMO  = 1'b1;

  localparam logic [GAIN_W-1:0] GAIN_RST = 24'd65536;
  localparam logic [TMO_W-1:0]  TMO_RST  = 12'd5;

  localparam logic [CNT_W-1:0] RATE_STEPS = 6'd44;

  typedef struct packed {
    logic            is_read;
    logic [TS_W-1:0] now_us;
  } item_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate_value;
    logic              timed_out;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIMIT,
    ST_CHECK,
    ST_AVG_CHK,
    ST_DIV_RATE,
    ST_EMIT
  } bk_state_t;

endpackage

// ===== src/pulse_rate_meter_core.sv =====
// Top level of the pulse rate meter: config registers, queues and execution core.
// Each request beat carries the current microsecond time. A pulse beat shifts that
// time into a window of the last DEPTH stamps and yields no result; the core stays
// idle. A read beat tests the newest stamp against timeout_s seconds, then averages
// the window span and divides 1e6 * conv_gain by that average, for a Q28.16 rate
// from a Q8.16 gain. The average comes from a reciprocal multiply by 1/(DEPTH-1);
// the rate runs on a restoring divider at one bit per cycle for 44 divide steps
// after the limit, check and average-check states; an emit state then waits for
// room in the result queue; a zero average or a timeout skips the divider. Two-entry
// queues on both sides let a new beat be pushed and an old result popped while busy.
module pulse_rate_meter_core #(
  parameter int DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_req_type,
  input  logic [31:0] in_now_us,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [43:0] out_rate_value,
  output logic        out_timed_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import prm_pkg::*;

  logic [GAIN_W-1:0] gain_r;
  logic [TMO_W-1:0]  tmo_r;
  logic              item_valid;
  item_t             item;
  logic              item_take;
  logic              res_push;
  res_t              res;
  logic              res_full;
  logic              cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RST;
      tmo_r  <= TMO_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_GAIN: gain_r <= cfg_data;
        CFG_TMO:  tmo_r  <= cfg_data[TMO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  prm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_req_type (in_req_type),
    .in_now_us   (in_now_us),
    .item_valid  (item_valid),
    .item        (item),
    .item_take   (item_take)
  );

  prm_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .conv_gain  (gain_r),
    .timeout_s  (tmo_r),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full)
  );

  prm_res_q u_res_q (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_push       (res_push),
    .res            (res),
    .res_full       (res_full),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_rate_value (out_rate_value),
    .out_timed_out  (out_timed_out)
  );

  // core never pushes a result into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  // core only takes a beat the front actually holds
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    item_take |-> item_valid)
    else $error("core took a beat from an empty front queue");

  a_gain_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_index == CFG_GAIN) |=> gain_r == $past(cfg_data))
    else $error("gain write lost");

endmodule

// ===== src/prm_front.sv =====
// Input side: accepts request beats, tags them and holds them in a two-entry queue.
module prm_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic                    in_req_type,
  input  logic [31:0]             in_now_us,
  output logic                    item_valid,
  output prm_pkg::item_t          item,
  input  logic                    item_take
);
  import prm_pkg::*;

  item_t      slot0_r, slot0_nxt;
  item_t      slot1_r, slot1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  item_t      new_item;
  logic       put;
  logic       take;

  assign in_full    = (cnt_r == 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = slot0_r;
  assign put        = in_push && !in_full;
  assign take       = item_take && item_valid;

  always_comb begin
    new_item.is_read = in_req_type;
    new_item.now_us  = in_now_us;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    if (put && take) begin
      if (cnt_r == 2'd1) begin
        slot0_nxt = new_item;
      end else begin
        slot0_nxt = slot1_r;
        slot1_nxt = new_item;
      end
    end else if (take) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end else if (put) begin
      if (cnt_r == 2'd0) begin
        slot0_nxt = new_item;
      end else begin
        slot1_nxt = new_item;
      end
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

// ===== src/prm_back.sv =====
// Execution side: timestamp window, timeout test, reciprocal average and serial rate divider.
module prm_back #(
  parameter int DEPTH = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    item_valid,
  input  prm_pkg::item_t          item,
  output logic                    item_take,
  input  logic [23:0]             conv_gain,
  input  logic [11:0]             timeout_s,
  output logic                    res_push,
  output prm_pkg::res_t           res,
  input  logic                    res_full
);
  import prm_pkg::*;

  // span / (DEPTH-1) as span * ceil(2^AVG_SH / (DEPTH-1)) >> AVG_SH, exact for 32-bit spans
  localparam int            AVG_SH  = TS_W + $clog2(DEPTH - 1);
  localparam logic [63:0]   AVG_M64 = ((64'd1 << AVG_SH) + 64'(DEPTH - 2)) / 64'(DEPTH - 1);
  localparam logic [TS_W:0] AVG_M   = (TS_W+1)'(AVG_M64);
  localparam int            AP_W    = 2 * TS_W + 8;

  bk_state_t          state_r, state_nxt;
  logic [TS_W-1:0]    win_r [DEPTH];
  logic [TS_W-1:0]    win_nxt [DEPTH];
  logic [TS_W-1:0]    now_r, now_nxt;
  logic [TS_W-1:0]    limit_r, limit_nxt;
  logic [RATE_W-1:0]  prod_r, prod_nxt;
  logic [RATE_W-1:0]  dvd_r, dvd_nxt;
  logic [TS_W-1:0]    dvs_r, dvs_nxt;
  logic [TS_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TS_W-1:0]    avg_r, avg_nxt;
  res_t               res_r, res_nxt;

  logic [TS_W-1:0]    age;
  logic [TS_W-1:0]    span;
  logic [AP_W-1:0]    avg_prod;
  logic [TS_W-1:0]    avg;
  logic [TS_W:0]      rem_sh;
  logic [TS_W:0]      diff;
  logic               qbit;
  logic [TS_W-1:0]    rem_step;
  logic [RATE_W-1:0]  dvd_step;

  assign age      = now_r - win_r[DEPTH-1];
  assign span     = win_r[DEPTH-1] - win_r[0];
  assign avg_prod = AP_W'(span) * AP_W'(AVG_M);
  assign avg      = avg_prod[AVG_SH +: TS_W];

  // one restoring divide step per cycle; quotient bits shift in at the bottom
  assign rem_sh   = {rem_r, dvd_r[RATE_W-1]};
  assign diff     = rem_sh - {1'b0, dvs_r};
  assign qbit     = !diff[TS_W];
  assign rem_step = qbit ? diff[TS_W-1:0] : rem_sh[TS_W-1:0];
  assign dvd_step = {dvd_r[RATE_W-2:0], qbit};

  assign res = res_r;

  always_comb begin
    state_nxt = state_r;
    win_nxt   = win_r;
    now_nxt   = now_r;
    limit_nxt = limit_r;
    prod_nxt  = prod_r;
    dvd_nxt   = dvd_r;
    dvs_nxt   = dvs_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    avg_nxt   = avg_r;
    res_nxt   = res_r;
    item_take = 1'b0;
    res_push  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          item_take = 1'b1;
          if (!item.is_read) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
              win_nxt[i] = win_r[i+1];
            end
            win_nxt[DEPTH-1] = item.now_us;
          end else begin
            now_nxt   = item.now_us;
            state_nxt = ST_LIMIT;
          end
        end
      end
      ST_LIMIT: begin
        limit_nxt = TS_W'({20'd0, timeout_s} * {12'd0, US_PER_S});
        prod_nxt  = {20'd0, conv_gain} * {24'd0, US_PER_S};
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (age > limit_r) begin
          for (int i = 0; i < DEPTH; i++) begin
            win_nxt[i] = now_r;
          end
          res_nxt.rate_value = '0;
          res_nxt.timed_out  = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          avg_nxt   = avg;
          state_nxt = ST_AVG_CHK;
        end
      end
      ST_AVG_CHK: begin
        if (avg_r == '0) begin
          res_nxt.rate_value = '0;
          res_nxt.timed_out  = 1'b0;
          state_nxt = ST_EMIT;
        end else begin
          dvd_nxt   = prod_r;
          dvs_nxt   = avg_r;
          rem_nxt   = '0;
          cnt_nxt   = RATE_STEPS;
          state_nxt = ST_DIV_RATE;
        end
      end
      ST_DIV_RATE: begin
        dvd_nxt = dvd_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          res_nxt.rate_value = dvd_step;
          res_nxt.timed_out  = 1'b0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int i = 0; i < DEPTH; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      win_r   <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r   <= now_nxt;
    limit_r <= limit_nxt;
    prod_r  <= prod_nxt;
    dvd_r   <= dvd_nxt;
    dvs_r   <= dvs_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    avg_r   <= avg_nxt;
    res_r   <= res_nxt;
  end

endmodule

// ===== src/prm_res_q.sv =====
// Output side: two-entry result queue in front of the pop port.
module prm_res_q (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    res_push,
  input  prm_pkg::res_t           res,
  output logic                    res_full,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [43:0]             out_rate_value,
  output logic                    out_timed_out
);
  import prm_pkg::*;

  res_t       slot0_r, slot0_nxt;
  res_t       slot1_r, slot1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       put;
  logic       take;

  assign res_full       = (cnt_r == 2'd2);
  assign out_empty      = (cnt_r == 2'd0);
  assign out_rate_value = slot0_r.rate_value;
  assign out_timed_out  = slot0_r.timed_out;
  assign put            = res_push && !res_full;
  assign take           = out_pop && !out_empty;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    if (put && take) begin
      if (cnt_r == 2'd1) begin
        slot0_nxt = res;
      end else begin
        slot0_nxt = slot1_r;
        slot1_nxt = res;
      end
    end else if (take) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end else if (put) begin
      if (cnt_r == 2'd0) begin
        slot0_nxt = res;
      end else begin
        slot1_nxt = res;
      end
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule
